>>> hdl/parad_pkg.sv
// Shared types and constants for the phase-angle ramp/dither firing controller.
// No dependencies; used by the interfaces and imported by all modules.
package parad_pkg;

	localparam int ANGLE_W = 8;
	localparam int DELTA_W = 7;
	localparam int TIME_W  = 14;

	localparam logic [ANGLE_W-1:0] ANGLE_MIN     = 8'd10;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd170;
	localparam logic [ANGLE_W-1:0] ANGLE_RESET   = 8'd170;
	localparam logic [TIME_W-1:0]  US_PER_DEGREE = 14'd55;
	localparam logic [TIME_W-1:0]  FULL_SPAN_US  = 14'd8800;
	localparam logic [DELTA_W-1:0] DELTA_RESET   = 7'd5;

	// register index of dither_delta in the config map
	localparam logic REG_DITHER_DELTA = 1'b0;

	typedef enum logic [1:0] {
		OP_RAMP   = 2'd0,
		OP_DITHER = 2'd1,
		OP_TIMING = 2'd2
	} op_t;

	typedef struct packed {
		logic               dither;
		logic [ANGLE_W-1:0] angle;
	} drive_state_t;

endpackage

>>> hdl/parad_if.sv
// Request and result channel interfaces for the firing controller.
// Depends on parad_pkg.
interface parad_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   operation;
	logic [parad_pkg::ANGLE_W-1:0] set_angle;

	modport source (output valid, operation, set_angle, input ready);
	modport sink   (input valid, operation, set_angle, output ready);
endinterface

interface parad_res_if;
	logic                         valid;
	logic                         ready;
	logic [parad_pkg::ANGLE_W-1:0] output_angle;
	logic [parad_pkg::TIME_W-1:0]  firing_delay_us;
	logic [parad_pkg::TIME_W-1:0]  off_time_us;
	logic                         dither_active;

	modport source (output valid, output_angle, firing_delay_us, off_time_us, dither_active,
		input ready);
	modport sink   (input valid, output_angle, firing_delay_us, off_time_us, dither_active,
		output ready);
endinterface

>>> hdl/parad_ctrl.sv
// Ramp/dither state machine: holds mode and angles, computes the state after a request.
// Depends on parad_pkg.
module parad_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    operation,
	input  logic [parad_pkg::ANGLE_W-1:0] set_angle,
	input  logic [parad_pkg::DELTA_W-1:0] dither_delta,
	output parad_pkg::drive_state_t       next_state
);
	import parad_pkg::*;

	logic               mode_q, mode_d;
	logic [ANGLE_W-1:0] current_q, current_d;
	logic [ANGLE_W-1:0] dither_q, dither_d;
	logic [ANGLE_W-1:0] driven_q, driven_d;
	logic [ANGLE_W-1:0] delta_x2;
	logic               in_window;

	assign delta_x2  = {dither_delta, 1'b0};
	assign in_window = ({1'b0, set_angle} >= ({1'b0, ANGLE_MIN} + {2'b00, dither_delta}))
		&& (({1'b0, set_angle} + {2'b00, dither_delta}) <= {1'b0, ANGLE_MAX});

	always_comb begin
		mode_d    = mode_q;
		current_d = current_q;
		dither_d  = dither_q;
		driven_d  = driven_q;
		case (operation)
			OP_RAMP: begin
				if (!mode_q) begin
					if (current_q == set_angle) begin
						mode_d   = 1'b1;
						dither_d = current_q + {1'b0, dither_delta};
					end else begin
						current_d = (current_q > set_angle) ? current_q - 8'd1
							: current_q + 8'd1;
						driven_d  = current_d;
					end
				end
			end
			OP_DITHER: begin
				if (mode_q) begin
					// target moved: back to ramping, driven angle stays
					if (current_q != set_angle) begin
						mode_d = 1'b0;
					end else if (in_window) begin
						if (dither_q > set_angle)
							dither_d = dither_q - delta_x2;
						else if (dither_q < set_angle)
							dither_d = dither_q + delta_x2;
						driven_d = dither_d;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			current_q <= ANGLE_RESET;
			dither_q  <= '0;
			driven_q  <= ANGLE_RESET;
		end else if (accept) begin
			mode_q    <= mode_d;
			current_q <= current_d;
			dither_q  <= dither_d;
			driven_q  <= driven_d;
		end
	end

	assign next_state.dither = mode_d;
	assign next_state.angle  = driven_d;

endmodule

>>> hdl/parad_timing.sv
// Gate timing from the driven angle: firing delay and remaining off time.
// Depends on parad_pkg.
module parad_timing (
	input  logic [parad_pkg::ANGLE_W-1:0] angle,
	output logic [parad_pkg::TIME_W-1:0]  firing_delay_us,
	output logic [parad_pkg::TIME_W-1:0]  off_time_us
);
	import parad_pkg::*;

	logic [ANGLE_W-1:0] above_min;
	logic [TIME_W-1:0]  product;

	assign above_min = angle - ANGLE_MIN;
	// 245 * 55 fits in 14 bits
	assign product   = TIME_W'({{(TIME_W-ANGLE_W){1'b0}}, above_min} * US_PER_DEGREE);

	always_comb begin
		firing_delay_us = (angle >= ANGLE_MIN) ? product : '0;
		off_time_us     = (firing_delay_us <= FULL_SPAN_US) ? FULL_SPAN_US - firing_delay_us
			: '0;
	end

endmodule

>>> hdl/phase_angle_ramp_dither_core.sv
// Phase-angle firing controller with soft-start ramp and dither.
// Result is registered on accept; one request per cycle unless a held result is not taken.
// The result register holds a result until taken; a new request is taken in the same cycle.
// arst_n clears state to ramping at 170 degrees, dither_delta to 5, no result pending.
// Depends on parad_pkg, parad_if, parad_ctrl, parad_timing.
module phase_angle_ramp_dither_core (
	input  logic        clk,
	input  logic        arst_n,
	parad_req_if.sink   req,
	parad_res_if.source res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import parad_pkg::*;

	logic               accept;
	logic [DELTA_W-1:0] delta_q;
	drive_state_t       next_state;
	logic [TIME_W-1:0]  delay_c, off_c;

	logic               res_valid_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [TIME_W-1:0]  delay_q, off_q;
	logic               dither_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DITHER_DELTA) ? {{(32-DELTA_W){1'b0}}, delta_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			delta_q <= DELTA_RESET;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_DITHER_DELTA)
			delta_q <= pwdata[DELTA_W-1:0];
	end

	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	parad_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (req.operation),
		.set_angle    (req.set_angle),
		.dither_delta (delta_q),
		.next_state   (next_state)
	);

	parad_timing u_timing (
		.angle           (next_state.angle),
		.firing_delay_us (delay_c),
		.off_time_us     (off_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (accept)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle_q  <= next_state.angle;
			delay_q  <= delay_c;
			off_q    <= off_c;
			dither_q <= next_state.dither;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.output_angle    = angle_q;
	assign res.firing_delay_us = delay_q;
	assign res.off_time_us     = off_q;
	assign res.dither_active   = dither_q;

endmodule

>>> hdl/parad_checker.sv
// Port-level checks for phase_angle_ramp_dither_core, attached by bind.
// Depends on parad_pkg.
module parad_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [parad_pkg::ANGLE_W-1:0] output_angle,
	input logic [parad_pkg::TIME_W-1:0]  firing_delay_us,
	input logic [parad_pkg::TIME_W-1:0]  off_time_us
);
	import parad_pkg::*;

	logic [TIME_W-1:0] exp_delay;

	always_comb begin
		exp_delay = (output_angle >= ANGLE_MIN)
			? TIME_W'({6'd0, output_angle - ANGLE_MIN} * US_PER_DEGREE) : '0;
	end

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_req_gives_res: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> res_valid)
		else $error("accepted request produced no result");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !req_ready)
		else $error("request taken while result register blocked");

	a_timing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> firing_delay_us == exp_delay
			&& ((firing_delay_us <= FULL_SPAN_US && off_time_us + firing_delay_us == FULL_SPAN_US)
			|| (firing_delay_us > FULL_SPAN_US && off_time_us == '0)))
		else $error("gate timing does not match output angle");

endmodule

bind phase_angle_ramp_dither_core parad_checker u_parad_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.output_angle    (res.output_angle),
	.firing_delay_us (res.firing_delay_us),
	.off_time_us     (res.off_time_us)
);
